### design/wrd_pkg.sv
// ----------------------------------------------------------------------------
// wrd_pkg
// Types, constants and the bytewise CRC-32 update for the log record deframer.
// ----------------------------------------------------------------------------
package wrd_pkg;

	localparam int unsigned BitsPerByte = 8;
	localparam logic [31:0] CrcAllOnes  = 32'hFFFF_FFFF;
	localparam logic [31:0] CrcPoly     = 32'hEDB8_8320;
	localparam logic [1:0]  LastIdx     = 2'd3;

	typedef enum logic [1:0] {
		PH_LEN = 2'd0,
		PH_SUM = 2'd1,
		PH_PAY = 2'd2
	} phase_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] payload_byte;
		logic       has_payload;
		logic       record_last;
		logic       record_good;
	} result_t;

	// Reflected CRC-32 update by one byte, unrolled into an XOR tree.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < BitsPerByte; k++) begin
			c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
		end
		return c;
	endfunction

	function automatic logic [31:0] put_le_byte(input logic [31:0] word, input logic [1:0] idx,
			input logic [7:0] b);
		logic [31:0] w;
		w = word;
		unique case (idx)
			2'd0: w[7:0]   = b;
			2'd1: w[15:8]  = b;
			2'd2: w[23:16] = b;
			2'd3: w[31:24] = b;
		endcase
		return w;
	endfunction

endpackage

### design/wal_record_deframer.sv
// ----------------------------------------------------------------------------
// wal_record_deframer
// Splits a write-ahead-log byte stream into length-prefixed records and
// checks each record payload against its stored CRC-32.
// ----------------------------------------------------------------------------
// The block takes one log byte per cycle and gives at most one result per
// request: payload bytes as they arrive, and a last flag with a good flag at
// the end of each record. Each request passes an input register and then a
// result register, and a new request is taken in every cycle while the output
// side keeps up. The rate is set by the combinational CRC byte update feeding
// back into the running CRC register. After a bad record no result is given
// until a request with the new-file flag arrives.
module wal_record_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tuser,   // [0] new_file
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
	output logic [1:0] m_axis_tuser,   // [0] has_payload, [1] record_good
	output logic       m_axis_tlast    // record_last
);

	logic         valid_s1;
	logic [7:0]   data_s1;
	logic         nf_s1;

	wrd_pkg::phase_t phase_q, phase_d, phase_e;
	logic [1:0]   idx_q, idx_d, idx_e;
	logic [31:0]  len_q, len_d, len_e;
	logic [31:0]  chk_q, chk_d, chk_e;
	logic [31:0]  left_q, left_d, left_e;
	logic [31:0]  crc_q, crc_d, crc_e;
	logic         stop_q, stop_d, stop_e;

	logic [31:0]  chk_new;
	logic [31:0]  crc_new;
	logic [31:0]  left_new;
	logic         pay_last;
	logic         pay_good;
	logic         empty_good;

	wrd_pkg::result_t res;
	wrd_pkg::result_t out_q;

	logic can_load;
	logic fire_s1;

	assign can_load      = !out_q.valid || m_axis_tready;
	assign fire_s1       = valid_s1 && can_load;
	assign s_axis_tready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
			nf_s1   <= s_axis_tuser;
		end
	end

	always_comb begin
		if (nf_s1) begin
			phase_e = wrd_pkg::PH_LEN;
			idx_e   = 2'd0;
			len_e   = 32'd0;
			chk_e   = 32'd0;
			left_e  = 32'd0;
			crc_e   = wrd_pkg::CrcAllOnes;
			stop_e  = 1'b0;
		end else begin
			phase_e = phase_q;
			idx_e   = idx_q;
			len_e   = len_q;
			chk_e   = chk_q;
			left_e  = left_q;
			crc_e   = crc_q;
			stop_e  = stop_q;
		end
	end

	assign chk_new    = wrd_pkg::put_le_byte(chk_e, idx_e, data_s1);
	assign crc_new    = wrd_pkg::crc_byte(crc_e, data_s1);
	assign left_new   = left_e - 32'd1;
	assign pay_last   = (left_new == 32'd0);
	assign pay_good   = ((crc_new ^ wrd_pkg::CrcAllOnes) == chk_e);
	assign empty_good = (chk_new == 32'd0);

	always_comb begin
		phase_d = phase_e;
		idx_d   = idx_e;
		len_d   = len_e;
		chk_d   = chk_e;
		left_d  = left_e;
		crc_d   = crc_e;
		stop_d  = stop_e;
		if (!stop_e) begin
			unique case (phase_e)
				wrd_pkg::PH_SUM: begin
					chk_d = chk_new;
					if (idx_e != wrd_pkg::LastIdx) begin
						idx_d = idx_e + 2'd1;
					end else begin
						idx_d = 2'd0;
						crc_d = wrd_pkg::CrcAllOnes;
						if (len_e == 32'd0) begin
							phase_d = wrd_pkg::PH_LEN;
							stop_d  = !empty_good;
						end else begin
							left_d  = len_e;
							phase_d = wrd_pkg::PH_PAY;
						end
					end
				end
				wrd_pkg::PH_PAY: begin
					crc_d  = crc_new;
					left_d = left_new;
					if (pay_last) begin
						stop_d  = !pay_good;
						phase_d = wrd_pkg::PH_LEN;
						idx_d   = 2'd0;
						crc_d   = wrd_pkg::CrcAllOnes;
					end
				end
				default: begin
					phase_d = wrd_pkg::PH_LEN;
					len_d   = wrd_pkg::put_le_byte(len_e, idx_e, data_s1);
					if (idx_e != wrd_pkg::LastIdx) begin
						idx_d = idx_e + 2'd1;
					end else begin
						idx_d   = 2'd0;
						phase_d = wrd_pkg::PH_SUM;
					end
				end
			endcase
		end
	end

	always_comb begin
		res = '0;
		if (!stop_e) begin
			unique case (phase_e)
				wrd_pkg::PH_SUM: begin
					if (idx_e == wrd_pkg::LastIdx && len_e == 32'd0) begin
						res.valid       = 1'b1;
						res.record_last = 1'b1;
						res.record_good = empty_good;
					end
				end
				wrd_pkg::PH_PAY: begin
					res.valid        = 1'b1;
					res.payload_byte = data_s1;
					res.has_payload  = 1'b1;
					res.record_last  = pay_last;
					res.record_good  = pay_last && pay_good;
				end
				default: begin
					res = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wrd_pkg::PH_LEN;
			idx_q   <= 2'd0;
			len_q   <= 32'd0;
			chk_q   <= 32'd0;
			left_q  <= 32'd0;
			crc_q   <= wrd_pkg::CrcAllOnes;
			stop_q  <= 1'b0;
		end else if (fire_s1) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			len_q   <= len_d;
			chk_q   <= chk_d;
			left_q  <= left_d;
			crc_q   <= crc_d;
			stop_q  <= stop_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (can_load) begin
			out_q.valid <= fire_s1 && res.valid;
			if (fire_s1 && res.valid) begin
				out_q.payload_byte <= res.payload_byte;
				out_q.has_payload  <= res.has_payload;
				out_q.record_last  <= res.record_last;
				out_q.record_good  <= res.record_good;
			end
		end
	end

	assign m_axis_tvalid   = out_q.valid;
	assign m_axis_tdata    = out_q.payload_byte;
	assign m_axis_tuser[0] = out_q.has_payload;
	assign m_axis_tuser[1] = out_q.record_good;
	assign m_axis_tlast    = out_q.record_last;

	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.has_payload) |-> (res.record_last && res.payload_byte == 8'd0))
		else $error("result without payload must close a record");

	a_good_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.record_last) |-> !res.record_good)
		else $error("good flag outside a record end");

	a_stopped_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && stop_q && !nf_s1) |-> !res.valid)
		else $error("result produced while replay is stopped");

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == wrd_pkg::PH_PAY) |-> (left_q != 32'd0 && idx_q == 2'd0))
		else $error("payload phase with no bytes left");

	a_stop_on_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && res.valid && res.record_last && !res.record_good) |=> stop_q)
		else $error("bad record did not stop replay");

endmodule

### verif/tb_wal_record_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wal_record_deframer
// Streams write-ahead-log bytes into the record deframer and checks every
// result against a cycle-free model of the record parser and CRC-32 check.
// A short directed log covers empty records, bad records, ignored bytes after
// a mismatch and restart by new-file mark. Random logs of mostly well-formed
// records with random payloads, corrupt checksums, truncated records and
// noise follow, under several sender and receiver idling mixes and one long
// receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_wal_record_deframer;

	typedef struct {
		logic [7:0] data_byte;
		logic       new_file;
	} log_byte_t;

	typedef struct {
		logic [7:0] payload_byte;
		logic       has_payload;
		logic       record_last;
		logic       record_good;
	} deframed_t;

	localparam int HoldOffCycles = 400;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'd0;
	logic       s_axis_tuser  = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;   // [7:0] payload_byte
	logic [1:0] m_axis_tuser;   // [0] has_payload, [1] record_good
	logic       m_axis_tlast;

	log_byte_t pending_bytes[$];
	deframed_t expected_outputs[$];
	log_byte_t next_req;
	deframed_t want;

	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	int  error_count    = 0;
	int  queued_count   = 0;
	bit  need_restart   = 1'b0;
	bit  hold_go        = 1'b0;
	bit  hold_off       = 1'b0;

	wrd_pkg::phase_t parse_ph;
	logic [1:0]  field_idx;
	logic [31:0] rec_len;
	logic [31:0] rec_sum;
	logic [31:0] rec_left;
	logic [31:0] rec_crc;
	logic        stopped;

	wal_record_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			if (c[0] ^ b[i])
				c = (c >> 1) ^ wrd_pkg::CrcPoly;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	task automatic restart_parse();
		parse_ph  = wrd_pkg::PH_LEN;
		field_idx = 2'd0;
		rec_len   = 32'd0;
		rec_sum   = 32'd0;
		rec_left  = 32'd0;
		rec_crc   = wrd_pkg::CrcAllOnes;
	endtask

	task automatic deframe_byte(input logic [7:0] b, input logic nf);
		deframed_t r;
		if (nf) begin
			restart_parse();
			stopped = 1'b0;
		end
		if (stopped)
			return;
		case (parse_ph)
			wrd_pkg::PH_SUM: begin
				rec_sum[int'(field_idx) * 8 +: 8] = b;
				if (field_idx != wrd_pkg::LastIdx) begin
					field_idx = field_idx + 2'd1;
				end else begin
					field_idx = 2'd0;
					rec_crc   = wrd_pkg::CrcAllOnes;
					if (rec_len == 32'd0) begin
						r = '{8'd0, 1'b0, 1'b1, rec_sum == 32'd0};
						parse_ph = wrd_pkg::PH_LEN;
						if (!r.record_good)
							stopped = 1'b1;
						expected_outputs.insert(expected_outputs.size(), r);
					end else begin
						rec_left = rec_len;
						parse_ph = wrd_pkg::PH_PAY;
					end
				end
			end
			wrd_pkg::PH_PAY: begin
				rec_crc  = crc32_update(rec_crc, b);
				rec_left = rec_left - 32'd1;
				r = '{b, 1'b1, rec_left == 32'd0, 1'b0};
				if (r.record_last) begin
					r.record_good = (rec_crc ^ wrd_pkg::CrcAllOnes) == rec_sum;
					if (!r.record_good)
						stopped = 1'b1;
					parse_ph  = wrd_pkg::PH_LEN;
					field_idx = 2'd0;
					rec_crc   = wrd_pkg::CrcAllOnes;
				end
				expected_outputs.insert(expected_outputs.size(), r);
			end
			default: begin
				parse_ph = wrd_pkg::PH_LEN;
				rec_len[int'(field_idx) * 8 +: 8] = b;
				if (field_idx != wrd_pkg::LastIdx) begin
					field_idx = field_idx + 2'd1;
				end else begin
					field_idx = 2'd0;
					parse_ph  = wrd_pkg::PH_SUM;
				end
			end
		endcase
	endtask

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("%s", msg);
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic nf);
		log_byte_t lb;
		lb.data_byte = b;
		lb.new_file  = nf;
		pending_bytes.insert(pending_bytes.size(), lb);
		queued_count++;
	endtask

	// Queues one record. A checksum is fixed up to match unless corrupt is set;
	// only the first keep bytes are queued, so a small keep truncates it.
	task automatic queue_record(input logic [31:0] len, input bit corrupt, input bit nf,
			input int keep);
		logic [7:0]  body[$];
		logic [31:0] crc;
		logic [31:0] sum;
		logic [7:0]  pb;
		int unsigned n;
		n   = (len > 32'd64) ? 64 : int'(len);
		crc = wrd_pkg::CrcAllOnes;
		for (int i = 0; i < 4; i++)
			body.insert(body.size(), len[i * 8 +: 8]);
		for (int i = 0; i < 4; i++)
			body.insert(body.size(), 8'd0);
		for (int unsigned i = 0; i < n; i++) begin
			pb  = 8'($urandom_range(0, 255));
			crc = crc32_update(crc, pb);
			body.insert(body.size(), pb);
		end
		sum = crc ^ wrd_pkg::CrcAllOnes;
		if (corrupt)
			sum = sum ^ (32'd1 << $urandom_range(0, 31));
		for (int i = 0; i < 4; i++)
			body[4 + i] = sum[i * 8 +: 8];
		for (int i = 0; i < body.size() && i < keep; i++)
			queue_byte(body[i], (i == 0) ? nf : 1'b0);
	endtask

	task automatic queue_random_log(input int target);
		int          start;
		int          pick;
		int          len_pick;
		logic [31:0] len;
		bit          nf;
		start = queued_count;
		while (queued_count - start < target) begin
			pick = $urandom_range(0, 99);
			nf   = need_restart || ($urandom_range(0, 9) == 0);
			need_restart = 1'b0;
			if (pick < 85) begin
				len_pick = $urandom_range(0, 99);
				if (len_pick < 15)
					len = 32'd0;
				else if (len_pick < 85)
					len = $urandom_range(1, 8);
				else
					len = $urandom_range(9, 40);
				queue_record(len, pick >= 75, nf, 1 << 20);
				need_restart = (pick >= 75);
			end else if (pick < 93) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 20);
				queue_record(len, 1'b0, nf,
					$urandom_range(1, 7 + ((len > 32'd64) ? 64 : int'(len))));
				need_restart = 1'b1;
			end else begin
				repeat ($urandom_range(1, 6))
					queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
				need_restart = 1'b1;
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || expected_outputs.size() != 0 || s_axis_tvalid
				|| hold_off)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				deframe_byte(s_axis_tdata, s_axis_tuser);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_req = pending_bytes.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= next_req.data_byte;
					s_axis_tuser  <= next_req.new_file;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_outputs.size() == 0) begin
					report_error($sformatf("unexpected result: byte %02h user %b last %b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast));
				end else begin
					want = expected_outputs.pop_front();
					if (m_axis_tdata !== want.payload_byte || m_axis_tuser[0] !== want.has_payload
							|| m_axis_tlast !== want.record_last
							|| m_axis_tuser[1] !== want.record_good)
						report_error($sformatf(
							"mismatch: expected byte %02h pay %b last %b good %b, got %02h %b %b %b",
							want.payload_byte, want.has_payload, want.record_last, want.record_good,
							m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]));
				end
			end
			m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		wait (hold_go);
		@(negedge clk);
		hold_off = 1'b1;
		repeat (HoldOffCycles) @(negedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#(64'd20_000_000);
		$display("tb_wal_record_deframer: done, errors");
		$finish;
	end

	initial begin
		restart_parse();
		stopped = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Empty good record, then an empty record whose checksum is not zero.
		queue_record(32'd0, 1'b0, 1'b1, 8);
		queue_record(32'd0, 1'b1, 1'b0, 8);
		// Ignored while stopped.
		queue_byte(8'hFF, 1'b0);
		// Restart with a one-byte record of zero and a bad checksum.
		queue_byte(8'h01, 1'b1);
		repeat (3) queue_byte(8'h00, 1'b0);
		repeat (4) queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b0);
		// A new log whose length is all ones, cut short by the next mark.
		queue_record(32'hFFFF_FFFF, 1'b0, 1'b1, 10);
		need_restart = 1'b1;
		wait_drained();

		queue_random_log(300);
		wait_drained();

		send_idle_pct = 83;
		queue_random_log(300);
		wait_drained();

		send_idle_pct  = 0;
		recv_stall_pct = 83;
		queue_random_log(300);
		wait_drained();

		send_idle_pct  = 23;
		recv_stall_pct = 23;
		queue_random_log(300);
		wait_drained();

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		queue_random_log(200);
		hold_go = 1'b1;
		wait (hold_off);
		wait_drained();

		repeat (10) @(negedge clk);
		if (expected_outputs.size() != 0)
			report_error($sformatf("%0d expected results never arrived",
				expected_outputs.size()));
		if (error_count == 0)
			$display("tb_wal_record_deframer: done, clean");
		else
			$display("tb_wal_record_deframer: done, errors");
		$finish;
	end

endmodule
